// ===== sv/bdy_pkg.sv =====
package bdy_pkg;

  // default pool size in granules
  localparam int DEF_POOL_GRANULES = 256;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_MRG_RD,
    S_MRG_EV,
    S_FIN,
    S_OUT
  } state_t;

  // memory port controls
  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    logic [15:0] raddr;
  } map_ctl_t;

  // smallest k with 2^k >= v, for a 9-bit size
  function automatic logic [3:0] ceil_log2_9(input logic [8:0] v);
    logic [3:0] r;
    r = 4'd9;
    for (int k = 8; k >= 0; k--) begin
      if ((10'd1 << k) >= {1'b0, v}) r = 4'(k);
    end
    return r;
  endfunction

endpackage

// ===== sv/buddy_allocator.sv =====
// Channel  Dir  Signals
// in       in   in_valid, in_ready, in_opcode, in_request_size, in_release_offset
// out      out  out_valid, out_ready, out_block_offset, out_block_order, out_status
//
// After reset a clearing pass writes every map entry, one per cycle
// (POOL entries, 256 by default), before the first word is taken.
// Allocate walks the block list, reading then evaluating each block, then splits the best fit.
// Free reads then evaluates the buddy in each merge step; everything runs on one map.
// One word at a time: in_ready is high only when idle, out holds until taken.
module buddy_allocator #(
  parameter int POOL_GRANULES = bdy_pkg::DEF_POOL_GRANULES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [8:0] in_request_size,
  input  logic [7:0] in_release_offset,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_block_offset,
  output logic [3:0] out_block_order,
  output logic [1:0] out_status
);
  import bdy_pkg::*;

  localparam int AW   = (POOL_GRANULES < 2) ? 1 : $clog2(POOL_GRANULES);
  localparam int OW   = $clog2(AW + 1);
  localparam int DW   = OW + 2;
  localparam int POOL = 2 ** AW;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW:0]   addr_r, addr_nxt;
  logic [OW-1:0] k_r, k_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [OW-1:0] bord_r, bord_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [OW-1:0] ord_r, ord_nxt;
  logic          op_r, op_nxt;
  logic [7:0]    res_off_r, res_off_nxt;
  logic [3:0]    res_ord_r, res_ord_nxt;
  logic [1:0]    res_st_r, res_st_nxt;

  map_ctl_t      ctl;
  logic [DW-1:0] wdata, rdata;

  logic          rd_head, rd_used;
  logic [OW-1:0] rd_ord;
  logic [AW:0]   scan_next;
  logic          hit, scan_end, merge_ok, size_bad, off_bad, accept;
  logic [AW-1:0] buddy, bud_bit, rel_addr, split_addr;
  logic [OW-1:0] req_k;
  logic [AW+7:0] rel_ext, off_ext;
  logic [OW+3:0] k_ext, ord_ext;

  bdy_map #(.AW(AW), .DW(DW)) u_map (
    .clk   (clk),
    .ctl   (ctl),
    .wdata (wdata),
    .rdata (rdata)
  );

  // map entry fields and decoded conditions
  assign rd_head   = rdata[DW-1];
  assign rd_used   = rdata[DW-2];
  assign rd_ord    = rdata[OW-1:0];
  assign accept    = in_valid && in_ready;
  assign scan_next = addr_r + ((AW+1)'(1) << rd_ord);
  assign scan_end  = (scan_next == (AW+1)'(POOL));
  assign hit       = rd_head && !rd_used && (rd_ord >= k_r)
                     && (!found_r || (rd_ord < bord_r));
  assign bud_bit   = AW'(1) << ord_r;
  assign buddy     = off_r ^ bud_bit;
  assign merge_ok  = rd_head && !rd_used && (rd_ord == ord_r);
  assign split_addr = best_r + (AW'(1) << (bord_r - OW'(1)));
  assign size_bad  = (in_request_size == 9'd0) || (32'(in_request_size) > POOL);
  assign off_bad   = (32'(in_release_offset) >= POOL);
  assign rel_ext   = {{AW{1'b0}}, in_release_offset};
  assign rel_addr  = rel_ext[AW-1:0];
  assign k_ext     = {{OW{1'b0}}, ceil_log2_9(in_request_size)};
  assign req_k     = k_ext[OW-1:0];
  assign off_ext   = {8'd0, off_r};
  assign ord_ext   = {4'd0, ord_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:      if (clr_r == AW'(POOL - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_ALLOC) state_nxt = size_bad ? S_OUT : S_SCAN_RD;
          else                       state_nxt = off_bad ? S_OUT : S_FREE_RD;
        end
      end
      S_SCAN_RD:  state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (scan_end) state_nxt = (found_r || hit) ? S_SPLIT : S_OUT;
        else          state_nxt = S_SCAN_RD;
      end
      S_SPLIT:    if (bord_r == k_r) state_nxt = S_FIN;
      S_FREE_RD:  state_nxt = S_FREE_CHK;
      S_FREE_CHK: state_nxt = (rd_head && rd_used) ? S_MRG_RD : S_OUT;
      S_MRG_RD:   state_nxt = (ord_r == OW'(AW)) ? S_FIN : S_MRG_EV;
      S_MRG_EV:   state_nxt = merge_ok ? S_MRG_RD : S_FIN;
      S_FIN:      state_nxt = S_OUT;
      S_OUT:      if (out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_CLR;
    endcase
  end

  // handshake and map port
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    ctl       = '0;
    wdata     = '0;
    unique case (state_r)
      S_CLR: begin
        ctl.we    = 1'b1;
        ctl.waddr = 16'(clr_r);
        wdata     = (clr_r == '0) ? {1'b1, 1'b0, OW'(AW)} : '0;
      end
      S_SCAN_RD: ctl.raddr = 16'(addr_r[AW-1:0]);
      S_SPLIT: begin
        ctl.we    = (bord_r != k_r);
        ctl.waddr = 16'(split_addr);
        wdata     = {1'b1, 1'b0, bord_r - OW'(1)};
      end
      S_FREE_RD: ctl.raddr = 16'(off_r);
      S_MRG_RD:  ctl.raddr = 16'(buddy);
      S_MRG_EV: begin
        ctl.we    = merge_ok;
        ctl.waddr = 16'(off_r | bud_bit);
      end
      S_FIN: begin
        ctl.we    = 1'b1;
        ctl.waddr = 16'(off_r);
        wdata     = {1'b1, (op_r == OP_ALLOC), ord_r};
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    clr_nxt     = clr_r;
    addr_nxt    = addr_r;
    k_nxt       = k_r;
    best_nxt    = best_r;
    bord_nxt    = bord_r;
    found_nxt   = found_r;
    off_nxt     = off_r;
    ord_nxt     = ord_r;
    op_nxt      = op_r;
    res_off_nxt = res_off_r;
    res_ord_nxt = res_ord_r;
    res_st_nxt  = res_st_r;
    unique case (state_r)
      S_CLR: clr_nxt = clr_r + AW'(1);
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_opcode;
          addr_nxt    = '0;
          found_nxt   = 1'b0;
          k_nxt       = req_k;
          off_nxt     = rel_addr;
          res_off_nxt = '0;
          res_ord_nxt = '0;
          if (in_opcode == OP_ALLOC) res_st_nxt = ST_BAD_SIZE;
          else                       res_st_nxt = ST_NOT_USED;
        end
      end
      S_SCAN_EV: begin
        addr_nxt = scan_next;
        if (hit) begin
          found_nxt = 1'b1;
          best_nxt  = addr_r[AW-1:0];
          bord_nxt  = rd_ord;
        end
        if (scan_end && !(found_r || hit)) res_st_nxt = ST_NO_FREE;
      end
      S_SPLIT: begin
        if (bord_r != k_r) begin
          bord_nxt = bord_r - OW'(1);
        end else begin
          off_nxt = best_r;
          ord_nxt = bord_r;
        end
      end
      S_FREE_CHK: ord_nxt = rd_ord;
      S_MRG_EV: begin
        if (merge_ok) begin
          off_nxt = off_r & ~bud_bit;
          ord_nxt = ord_r + OW'(1);
        end
      end
      S_FIN: begin
        res_off_nxt = off_ext[7:0];
        res_ord_nxt = ord_ext[3:0];
        res_st_nxt  = ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      found_r <= found_nxt;
    end
    addr_r    <= addr_nxt;
    k_r       <= k_nxt;
    best_r    <= best_nxt;
    bord_r    <= bord_nxt;
    off_r     <= off_nxt;
    ord_r     <= ord_nxt;
    op_r      <= op_nxt;
    res_off_r <= res_off_nxt;
    res_ord_r <= res_ord_nxt;
    res_st_r  <= res_st_nxt;
  end

  assign out_block_offset = res_off_r;
  assign out_block_order  = res_ord_r;
  assign out_status       = res_st_r;

endmodule

// ===== sv/bdy_map.sv =====
module bdy_map #(
  parameter int AW = 8,
  parameter int DW = 6
) (
  input  logic                 clk,
  input  bdy_pkg::map_ctl_t    ctl,
  input  logic [DW-1:0]        wdata,
  output logic [DW-1:0]        rdata
);
  import bdy_pkg::*;

  logic [DW-1:0] mem [2**AW];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr[AW-1:0]] <= wdata;
    end
    rdata <= mem[ctl.raddr[AW-1:0]];
  end

endmodule
